/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the blur block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define RGBB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that ante at one edge is followed by cons at the next edge.
`define RGBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rgbb_pkg.sv */
// ----------------------------------------------------------------------------
// rgbb_pkg
// Types and constants shared by the 3x3 blur stream modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbb_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W     = 32;
  localparam int RGB_W     = 24;
  localparam int ALPHA_W   = 8;
  localparam int OUT_COL_W = 11;
  localparam int OUT_ROW_W = 12;

  localparam int CFG_W_BITS = 12;
  localparam int CFG_H_BITS = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_W_BITS-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 13'd480;

  // Results per input at most, and record queue depth.
  localparam int MAX_RES    = 4;
  localparam int SLOT_W     = $clog2(MAX_RES);
  localparam int EMIT_DEPTH = 4;

  // Window: [row][col], row 0 is the oldest line, col 2 the newest pixel.
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // All results caused by one input: shared blur value plus per-result
  // alpha and coordinates, slots 0..last valid.
  typedef struct packed {
    logic [RGB_W-1:0]                    rgb;
    logic [SLOT_W-1:0]                   last;
    logic [MAX_RES-1:0][ALPHA_W-1:0]     alpha;
    logic [MAX_RES-1:0][OUT_COL_W-1:0]   col;
    logic [MAX_RES-1:0][OUT_ROW_W-1:0]   row;
  } emit_rec_t;

endpackage

`default_nettype wire

/* hdl/rgbb_filter.sv */
// ----------------------------------------------------------------------------
// rgbb_filter
// 1-2-1 / 2-4-2 / 1-2-1 kernel over a 3x3 window, per color channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbb_filter (
  input  rgbb_pkg::win_t                 win,
  output logic [rgbb_pkg::RGB_W-1:0]     rgb
);

  // Weighted sum fits in 12 bits (16 * 255).
  function automatic logic [7:0] blur_ch(input rgbb_pkg::win_t w, input int sh);
    logic [11:0] s;
    s = 12'(w[0][0][sh +: 8]) + {3'd0, w[0][1][sh +: 8], 1'b0} + 12'(w[0][2][sh +: 8])
      + {3'd0, w[1][0][sh +: 8], 1'b0} + {2'd0, w[1][1][sh +: 8], 2'b00}
      + {3'd0, w[1][2][sh +: 8], 1'b0}
      + 12'(w[2][0][sh +: 8]) + {3'd0, w[2][1][sh +: 8], 1'b0} + 12'(w[2][2][sh +: 8]);
    return s[11:4];
  endfunction

  assign rgb = {blur_ch(win, 16), blur_ch(win, 8), blur_ch(win, 0)};

endmodule

`default_nettype wire

/* hdl/rgbb_emit.sv */
// ----------------------------------------------------------------------------
// rgbb_emit
// Record queue that holds result groups and hands them out one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbb_emit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push_valid,
  output logic                               push_ready,
  input  rgbb_pkg::emit_rec_t                push_rec,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rgbb_pkg::PIX_W-1:0]         out_pixel_out,
  output logic [rgbb_pkg::OUT_COL_W-1:0]     out_col,
  output logic [rgbb_pkg::OUT_ROW_W-1:0]     out_row,
  output logic                               out_run_last
);

  localparam int PW = $clog2(rgbb_pkg::EMIT_DEPTH);
  localparam int NW = $clog2(rgbb_pkg::EMIT_DEPTH + 1);

  rgbb_pkg::emit_rec_t                 fifo_r [rgbb_pkg::EMIT_DEPTH];
  rgbb_pkg::emit_rec_t                 head;
  logic [PW-1:0]                       wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]                       count_r, count_nxt;
  logic [rgbb_pkg::SLOT_W-1:0]         slot_r;
  logic                                push_fire, out_fire, pop;

  assign push_ready = (count_r != NW'(rgbb_pkg::EMIT_DEPTH));
  assign push_fire  = push_valid && push_ready;
  assign out_valid  = (count_r != '0);
  assign head       = fifo_r[rd_ptr_r];
  assign out_fire   = out_valid && out_ready;
  assign out_run_last = (slot_r == head.last);
  assign pop        = out_fire && out_run_last;

  assign out_pixel_out = {head.alpha[slot_r], head.rgb};
  assign out_col       = head.col[slot_r];
  assign out_row       = head.row[slot_r];

  always_comb begin
    count_nxt = count_r;
    if (push_fire && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push_fire) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      slot_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PW'(rgbb_pkg::EMIT_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(rgbb_pkg::EMIT_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
        slot_r   <= '0;
      end else if (out_fire) begin
        slot_r <= slot_r + rgbb_pkg::SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      fifo_r[wr_ptr_r] <= push_rec;
    end
  end

  `include "assert_macros.svh"

  `RGBB_ASSERT(a_count_bound, clk, rst_n, count_r <= NW'(rgbb_pkg::EMIT_DEPTH), "queue overfilled")
  `RGBB_ASSERT_NEXT(a_group_holds, clk, rst_n, out_fire && !out_run_last, out_valid && (rd_ptr_r == $past(rd_ptr_r)), "result group dropped before its last result")
  `RGBB_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel_out), "result changed while waiting")

endmodule

`default_nettype wire

/* hdl/rgb_blur_3x3_stream.sv */
// ----------------------------------------------------------------------------
// rgb_blur_3x3_stream
// Streaming 3x3 blur over ARGB pixels with clamped border handling.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | transfer
//   --------+-----------------------------------------+--------------------------
//   in      | in_valid/in_ready, in_pixel_in          | one pixel, raster order
//   out     | out_valid/out_ready, pixel, col, row,   | one blurred pixel
//           | out_run_last                            |
//   cfg     | cfg_wr_en, cfg_index, cfg_data          | register write, no wait
//
// One pixel per clock is accepted while the record queue has room. A transaction
// passes the input stage (line memory read) and is then folded into the
// window; a pixel that completes a center queues a group of one to four
// results, the first offered once the group is in the record queue. The
// output port drains one result per clock while out_ready is high, so rows
// 1 and H-2 and the border columns, which emit two to four results per
// pixel, stall the input once the four-group record queue is full.
// Reset is synchronous; the line memory has no clearing pass since stale
// entries are read only in rows 0 and 1, which yield no results.
// A write to either frame register restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_blur_3x3_stream #(
  parameter int MAX_WIDTH  = rgbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rgbb_pkg::PIX_W-1:0]           in_pixel_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rgbb_pkg::PIX_W-1:0]           out_pixel_out,
  output logic [rgbb_pkg::OUT_COL_W-1:0]       out_col,
  output logic [rgbb_pkg::OUT_ROW_W-1:0]       out_row,
  output logic                                 out_run_last,
  input  logic                                 cfg_wr_en,
  input  logic [rgbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgbb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Column and row counter widths, and widths able to hold the clamped size.
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WDW = (WW > rgbb_pkg::CFG_W_BITS) ? WW : rgbb_pkg::CFG_W_BITS;
  localparam int HDW = (HW > rgbb_pkg::CFG_H_BITS) ? HW : rgbb_pkg::CFG_H_BITS;
  localparam int LW  = 2 * rgbb_pkg::PIX_W;
  localparam int NW  = $clog2(rgbb_pkg::MAX_RES + 1);

  // Configuration registers and clamped frame size.
  logic [rgbb_pkg::CFG_W_BITS-1:0] cfg_width_r;
  logic [rgbb_pkg::CFG_H_BITS-1:0] cfg_height_r;
  logic [WDW-1:0]                  w_raw, w_eff;
  logic [HDW-1:0]                  h_raw, h_eff;
  logic                            cfg_hit;

  // Frame position of the next pixel to accept.
  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic          last_col, last_row, in_fire;

  // Input stage: pixel, its position, and the line memory read.
  logic                      s0_valid_r;
  logic [rgbb_pkg::PIX_W-1:0] s0_px_r;
  logic [CW-1:0]             s0_col_r;
  logic [RW-1:0]             s0_row_r;
  logic                      s0_fire, s0_emit;

  // Each entry holds {upper line, lower line} for one column.
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] line_rd_r;

  rgbb_pkg::win_t win_r, win_nxt;

  // Result group assembly.
  logic [CW-1:0]                            cx;
  logic [RW-1:0]                            cy;
  logic [2:0]                               cpres, rpres;
  logic [2:0][rgbb_pkg::OUT_COL_W-1:0]      colv;
  logic [2:0][rgbb_pkg::OUT_ROW_W-1:0]      rowv;
  logic [NW-1:0]                            n_res;
  logic [rgbb_pkg::RGB_W-1:0]               blur_rgb;
  rgbb_pkg::emit_rec_t                      rec;
  logic                                     push_ready;

  // ---------------------------------------------------------------- config
  assign cfg_hit = cfg_wr_en &&
                   ((cfg_index == rgbb_pkg::REG_IMAGE_WIDTH) ||
                    (cfg_index == rgbb_pkg::REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= rgbb_pkg::RESET_WIDTH;
      cfg_height_r <= rgbb_pkg::RESET_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rgbb_pkg::REG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data[rgbb_pkg::CFG_W_BITS-1:0];
        rgbb_pkg::REG_IMAGE_HEIGHT: cfg_height_r <= cfg_data[rgbb_pkg::CFG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp into [3, MAX]; stored bits stay as written.
  assign w_raw = WDW'(cfg_width_r);
  assign h_raw = HDW'(cfg_height_r);
  assign w_eff = (w_raw < WDW'(3)) ? WDW'(3) :
                 (w_raw > WDW'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : w_raw;
  assign h_eff = (h_raw < HDW'(3)) ? HDW'(3) :
                 (h_raw > HDW'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : h_raw;

  // -------------------------------------------------------------- counters
  assign in_ready = !s0_valid_r || s0_fire;
  assign in_fire  = in_valid && in_ready;
  assign last_col = (WDW'(col_cnt_r) + WDW'(1)) >= w_eff;
  assign last_row = (HDW'(row_cnt_r) + HDW'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cfg_hit) begin
      // Restart the frame on a write to either frame register.
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  // ----------------------------------------------------------- input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_fire) begin
      s0_valid_r <= 1'b1;
    end else if (s0_fire) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_px_r  <= in_pixel_in;
      s0_col_r <= col_cnt_r;
      s0_row_r <= row_cnt_r;
    end
  end

  // Read at accept; write the shifted column back when the pixel leaves
  // the input stage. The same column is read again only a full row later,
  // well after the write.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_rd_r <= line_mem[col_cnt_r];
    end
    if (s0_fire) begin
      line_mem[s0_col_r] <= {line_rd_r[rgbb_pkg::PIX_W-1:0], s0_px_r};
    end
  end

  // Hold the pixel until the queue can take its result group.
  assign s0_emit = (s0_col_r >= CW'(2)) && (s0_row_r >= RW'(2));
  assign s0_fire = s0_valid_r && (!s0_emit || push_ready);

  // ---------------------------------------------------------------- window
  always_comb begin
    win_nxt = win_r;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = line_rd_r[LW-1:rgbb_pkg::PIX_W];
    win_nxt[1][2] = line_rd_r[rgbb_pkg::PIX_W-1:0];
    win_nxt[2][2] = s0_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s0_fire) begin
      win_r <= win_nxt;
    end
  end

  rgbb_filter u_filter (
    .win (win_nxt),
    .rgb (blur_rgb)
  );

  // ---------------------------------------------------------- result group
  // Completed center is (cx, cy). Border pixels take the same blur value;
  // slot 0 is the left/top border, slot 1 the center, slot 2 the right/bottom.
  assign cx = s0_col_r - CW'(1);
  assign cy = s0_row_r - RW'(1);

  assign cpres[0] = (cx == CW'(1));
  assign cpres[1] = 1'b1;
  assign cpres[2] = (WDW'(cx) == (w_eff - WDW'(2)));
  assign rpres[0] = (cy == RW'(1));
  assign rpres[1] = 1'b1;
  assign rpres[2] = (HDW'(cy) == (h_eff - HDW'(2)));

  assign colv[0] = '0;
  assign colv[1] = rgbb_pkg::OUT_COL_W'(cx);
  assign colv[2] = rgbb_pkg::OUT_COL_W'(w_eff - WDW'(1));
  assign rowv[0] = '0;
  assign rowv[1] = rgbb_pkg::OUT_ROW_W'(cy);
  assign rowv[2] = rgbb_pkg::OUT_ROW_W'(h_eff - HDW'(1));

  // Walk the 3x3 border grid in row-major order; drop past four results.
  // Window position (i, j) is exactly the pixel each result takes alpha from.
  always_comb begin
    rec     = '0;
    n_res   = '0;
    rec.rgb = blur_rgb;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rpres[i] && cpres[j] && (n_res < NW'(rgbb_pkg::MAX_RES))) begin
          rec.alpha[n_res[rgbb_pkg::SLOT_W-1:0]] =
            win_nxt[i][j][rgbb_pkg::PIX_W-1:rgbb_pkg::RGB_W];
          rec.col[n_res[rgbb_pkg::SLOT_W-1:0]] = colv[j];
          rec.row[n_res[rgbb_pkg::SLOT_W-1:0]] = rowv[i];
          n_res = n_res + NW'(1);
        end
      end
    end
    rec.last = rgbb_pkg::SLOT_W'(n_res - NW'(1));
  end

  rgbb_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .push_valid    (s0_valid_r && s0_emit),
    .push_ready    (push_ready),
    .push_rec      (rec),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_run_last  (out_run_last)
  );

  `include "assert_macros.svh"

  `RGBB_ASSERT(a_col_in_frame, clk, rst_n, WDW'(col_cnt_r) < w_eff, "column counter beyond frame width")
  `RGBB_ASSERT(a_row_in_frame, clk, rst_n, HDW'(row_cnt_r) < h_eff, "row counter beyond frame height")
  `RGBB_ASSERT_NEXT(a_stage_holds, clk, rst_n, s0_valid_r && !s0_fire && !cfg_hit, s0_valid_r && (s0_col_r == $past(s0_col_r)), "stalled pixel lost from input stage")

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking regression for rgb_blur_3x3_stream
// Streams ARGB frames of many sizes through the blur block and compares
// every blurred pixel, its coordinates and its group-end flag against an
// in-bench prediction. Both handshake sides idle at random, the receiver
// also holds off for long stretches, and the frame registers are rewritten
// between phases, including out-of-range and ignored writes.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Index codes past the register list; the block must ignore them.
  localparam logic [rgbb_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [rgbb_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Cycles to let an item that yields no pixel clear the input stage and
  // the group queue before the frame registers change.
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_WAIT_LIMIT = 50000;
  localparam int TIMEOUT_NS     = 5_000_000;

  // One blurred pixel as it leaves the block.
  typedef struct packed {
    logic [rgbb_pkg::PIX_W-1:0]     pixel;
    logic [rgbb_pkg::OUT_COL_W-1:0] col;
    logic [rgbb_pkg::OUT_ROW_W-1:0] row;
    logic                           last;
  } blurred_px_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [rgbb_pkg::PIX_W-1:0]      in_pixel_in = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [rgbb_pkg::PIX_W-1:0]      out_pixel_out;
  logic [rgbb_pkg::OUT_COL_W-1:0]  out_col;
  logic [rgbb_pkg::OUT_ROW_W-1:0]  out_row;
  logic                            out_run_last;
  logic                            cfg_wr_en = 1'b0;
  logic [rgbb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rgbb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Idle rates in percent, and a long receiver hold-off handed to the
  // receiver process as a cycle count.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int fail_count = 0;

  // Predicted blur state: the two stored rows, the 3x3 window, the frame
  // position and the raw register contents.
  logic [rgbb_pkg::PIX_W-1:0]      older_line [rgbb_pkg::DEF_MAX_WIDTH];
  logic [rgbb_pkg::PIX_W-1:0]      newer_line [rgbb_pkg::DEF_MAX_WIDTH];
  logic [rgbb_pkg::PIX_W-1:0]      window_px [3][3];
  int unsigned                     col_cnt;
  int unsigned                     row_cnt;
  logic [rgbb_pkg::CFG_W_BITS-1:0] width_reg;
  logic [rgbb_pkg::CFG_H_BITS-1:0] height_reg;

  // Blurred pixels still owed by the block, oldest first.
  blurred_px_t expected_px_q[$];
  blurred_px_t head_px;

  rgb_blur_3x3_stream dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_out(out_pixel_out),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_run_last (out_run_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Weighted 1-2-1 sum of one color channel over the window, divided by 16.
  function automatic logic [7:0] blur_chan(input int sh);
    int unsigned acc;
    int i;
    int j;
    acc = 0;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        acc += ((i == 1) ? 2 : 1) * ((j == 1) ? 2 : 1) * ((window_px[i][j] >> sh) & 32'hFF);
      end
    end
    return 8'((acc >> 4) & 32'hFF);
  endfunction

  function automatic void clear_blur_state();
    int k;
    for (k = 0; k < rgbb_pkg::DEF_MAX_WIDTH; k++) begin
      older_line[k] = '0;
      newer_line[k] = '0;
    end
    for (k = 0; k < 9; k++) window_px[k / 3][k % 3] = '0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = rgbb_pkg::RESET_WIDTH;
    height_reg = rgbb_pkg::RESET_HEIGHT;
  endfunction

  function automatic void apply_reg_write(input logic [rgbb_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [rgbb_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rgbb_pkg::REG_IMAGE_WIDTH: begin
        width_reg = data[rgbb_pkg::CFG_W_BITS-1:0];
        col_cnt = 0;
        row_cnt = 0;
      end
      rgbb_pkg::REG_IMAGE_HEIGHT: begin
        height_reg = data[rgbb_pkg::CFG_H_BITS-1:0];
        col_cnt = 0;
        row_cnt = 0;
      end
      // Spare indexes leave the frame position alone.
      default: ;
    endcase
  endfunction

  // Fold one accepted pixel into the window and queue the blurred pixels
  // that it completes.
  function automatic void predict_blur(input logic [rgbb_pkg::PIX_W-1:0] px);
    int unsigned w, h, c, r, cx, cy, nc, nr, total, n;
    int unsigned cols[3];
    int unsigned rows[3];
    int i, j, k;
    logic [rgbb_pkg::PIX_W-1:0] top, mid;
    logic [rgbb_pkg::RGB_W-1:0] rgb;
    blurred_px_t res;
    w = clamp_dim(width_reg, rgbb_pkg::DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, rgbb_pkg::DEF_MAX_HEIGHT);
    c = col_cnt;
    r = row_cnt;
    top = older_line[c];
    mid = newer_line[c];
    older_line[c] = mid;
    newer_line[c] = px;
    for (k = 0; k < 3; k++) begin
      window_px[k][0] = window_px[k][1];
      window_px[k][1] = window_px[k][2];
    end
    window_px[0][2] = top;
    window_px[1][2] = mid;
    window_px[2][2] = px;

    if (c >= 2 && r >= 2) begin
      cx = c - 1;
      cy = r - 1;
      rgb = {blur_chan(16), blur_chan(8), blur_chan(0)};
      nc = 0;
      nr = 0;
      // Border columns and rows repeat the nearest interior center.
      if (cx == 1) begin
        cols[nc] = 0;
        nc++;
      end
      cols[nc] = cx;
      nc++;
      if (cx == w - 2) begin
        cols[nc] = w - 1;
        nc++;
      end
      if (cy == 1) begin
        rows[nr] = 0;
        nr++;
      end
      rows[nr] = cy;
      nr++;
      if (cy == h - 2) begin
        rows[nr] = h - 1;
        nr++;
      end
      // Narrow or short frames can owe more than a group holds; drop the rest.
      total = nr * nc;
      if (total > rgbb_pkg::MAX_RES) total = rgbb_pkg::MAX_RES;
      n = 0;
      for (i = 0; i < nr; i++) begin
        for (j = 0; j < nc; j++) begin
          if (n < total) begin
            res.pixel = {window_px[rows[i] + 1 - cy][cols[j] + 1 - cx]
                                  [rgbb_pkg::PIX_W-1:rgbb_pkg::RGB_W], rgb};
            res.col = rgbb_pkg::OUT_COL_W'(cols[j]);
            res.row = rgbb_pkg::OUT_ROW_W'(rows[i]);
            res.last = (n == total - 1);
            expected_px_q.push_back(res);
            n++;
          end
        end
      end
    end

    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // Track register writes and accepted pixels in the order the block sees them.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_blur_state();
    end else begin
      if (cfg_wr_en) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_blur(in_pixel_in);
    end
  end

  // --------------------------------------------------------------------------
  // Result checking: pop the oldest expectation for every output transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_px_q.size() == 0) begin
        $error("unexpected blurred pixel at col %0d row %0d", out_col, out_row);
        fail_count++;
      end else begin
        head_px = expected_px_q.pop_front();
        if (out_pixel_out !== head_px.pixel) begin
          $error("pixel_out mismatch: expected %h, got %h", head_px.pixel, out_pixel_out);
          fail_count++;
        end
        if (out_col !== head_px.col) begin
          $error("out_col mismatch: expected %0d, got %0d", head_px.col, out_col);
          fail_count++;
        end
        if (out_row !== head_px.row) begin
          $error("out_row mismatch: expected %0d, got %0d", head_px.row, out_row);
          fail_count++;
        end
        if (out_run_last !== head_px.last) begin
          $error("run_last mismatch: expected %0b, got %0b", head_px.last, out_run_last);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, or a long hold-off when one is requested.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register tasks; all start and end on a falling edge.
  // --------------------------------------------------------------------------

  // Offer one pixel, hold it until the block takes it.
  task automatic send_pixel(input logic [rgbb_pkg::PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    int k;
    for (k = 0; k < count; k++) send_pixel($urandom);
  endtask

  // Drop valid and wait until every owed pixel is out, then let the
  // pipeline settle.
  task automatic wait_blur_drained();
    in_valid <= 1'b0;
    while (expected_px_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rgbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rgbb_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Go idle, then program both frame dimensions (raw values, may be clamped).
  task automatic set_frame(input int w_raw, input int h_raw);
    wait_blur_drained();
    write_reg(rgbb_pkg::REG_IMAGE_WIDTH, rgbb_pkg::CFG_DATA_W'(w_raw));
    write_reg(rgbb_pkg::REG_IMAGE_HEIGHT, rgbb_pkg::CFG_DATA_W'(h_raw));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Smallest frames with saturating and alternating pixels: the 3x3 frame
  // owes nine border copies of one center and must be cut to four; the
  // 4x4 frame puts four-pixel groups on every corner.
  task automatic test_corner_frames();
    int k;
    logic [rgbb_pkg::PIX_W-1:0] px;
    set_frame(3, 3);
    for (k = 0; k < 9; k++) begin
      case (k)
        0: px = '0;
        1: px = '1;
        2: px = 32'hFF00FF00;
        3: px = 32'h00FF00FF;
        4: px = 32'h80808080;
        5: px = 32'h7F7F7F7F;
        6: px = 32'hAAAAAAAA;
        7: px = 32'h55555555;
        default: px = 32'hFFFFFF00;
      endcase
      send_pixel(px);
    end
    set_frame(4, 4);
    for (k = 0; k < 16; k++) begin
      px = (((k + k / 4) % 2) != 0) ? '1 : {8'(k * 16), 24'h0};
      send_pixel(px);
    end
  endtask

  // Out-of-range sizes clamp to three; width ignores data bit 12.
  task automatic test_register_clamps();
    set_frame(13'h1005, 0);
    send_random(15);
    set_frame(1, 2);
    send_random(9);
  endtask

  // Writes to spare indexes must not restart the frame.
  task automatic test_ignored_index();
    set_frame(6, 5);
    send_random(10);
    wait_blur_drained();
    write_reg(REG_SPARE_A, rgbb_pkg::CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, rgbb_pkg::CFG_DATA_W'($urandom));
    send_random(20);
  endtask

  // A write in mid-frame restarts at row 0, column 0.
  task automatic test_frame_restart();
    set_frame(7, 6);
    send_random(20);
    wait_blur_drained();
    write_reg(rgbb_pkg::REG_IMAGE_WIDTH, rgbb_pkg::CFG_DATA_W'(7));
    send_random(42);
  endtask

  // Hold the receiver off long enough to fill the block and stall its
  // input, then pause the sender until every owed pixel is out.
  task automatic test_output_stall();
    set_frame(3, 12);
    hold_request = 400;
    send_random(60);
    wait_blur_drained();
    send_random(36);
  endtask

  // Widest row (width clamped down from 4095): the start of row 0 yields
  // nothing. Then the tallest frame (height clamped down from 8191).
  task automatic test_widest_frames();
    set_frame(4095, 3);
    send_random(60);
    set_frame(3, 8191);
    send_random(36);
  endtask

  // Mostly whole small frames with random content; now and then an
  // out-of-range size or a frame cut short by the next reconfiguration.
  task automatic test_random_frames(input int n_items);
    int sent, pick, w_raw, h_raw, w_use, h_use, rows_sent, frame_len, total;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(9);
      w_raw = $urandom_range(3, 16);
      h_raw = $urandom_range(3, 6);
      if (pick == 0) w_raw = $urandom_range(0, 2);
      else if (pick == 1) h_raw = $urandom_range(0, 2);
      else if (pick == 2) h_raw = $urandom_range(rgbb_pkg::DEF_MAX_HEIGHT + 1, 8191);
      w_use = clamp_dim(w_raw, rgbb_pkg::DEF_MAX_WIDTH);
      h_use = clamp_dim(h_raw, rgbb_pkg::DEF_MAX_HEIGHT);
      rows_sent = (h_use > 8) ? $urandom_range(3, 10) : h_use;
      frame_len = w_use * rows_sent;
      total = frame_len * $urandom_range(1, 2);
      if ($urandom_range(3) == 0) total += $urandom_range(1, frame_len - 1);
      if (total > n_items - sent) total = n_items - sent;
      set_frame(w_raw, h_raw);
      send_random(total);
      sent += total;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int guard;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Slow receiver, mostly busy sender.
    send_idle_pct = 23;
    recv_idle_pct = 75;
    test_corner_frames();
    test_register_clamps();
    test_random_frames(45);

    // Slow sender, mostly ready receiver.
    send_idle_pct = 75;
    recv_idle_pct = 23;
    test_ignored_index();
    test_frame_restart();
    test_output_stall();
    test_random_frames(45);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_widest_frames();
    test_random_frames(45);

    // Drain, then allow any stray output to show up.
    in_valid <= 1'b0;
    guard = 0;
    while (expected_px_q.size() != 0 && guard < END_WAIT_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_px_q.size() != 0) begin
      $error("%0d blurred pixels never arrived", expected_px_q.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop if the handshakes hang.
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
